// ----- sv/tcgr_pkg.sv -----
// ----------------------------------------------------------------------------
// Text console glyph renderer package
// Request and command codes, character codes and register reset values.
// ----------------------------------------------------------------------------
package tcgr_pkg;

  typedef enum logic [1:0] {
    REQ_PUT_CHAR  = 2'd0,
    REQ_LOAD_FONT = 2'd1,
    REQ_CLEAR     = 2'd2
  } req_type_e;

  typedef enum logic [1:0] {
    CMD_GLYPH_ROW = 2'd0,
    CMD_SCROLL_UP = 2'd1,
    CMD_CLEAR_FB  = 2'd2
  } cmd_kind_e;

  // Register select (byte address bit 2)
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  localparam logic [7:0] CH_BACKSPACE = 8'd8;
  localparam logic [7:0] CH_NEWLINE   = 8'd10;
  localparam logic [7:0] CH_RETURN    = 8'd13;
  localparam logic [7:0] CH_SPACE     = 8'd32;

  localparam logic [11:0] WIDTH_RST  = 12'd640;
  localparam logic [11:0] HEIGHT_RST = 12'd480;

  // Font store: 256 glyphs with a stride of 16 rows
  localparam int FontAw     = 12;
  localparam int FontStride = 4;

endpackage

// ----- sv/text_console_glyph_renderer.sv -----
// ----------------------------------------------------------------------------
// Text console glyph renderer
// Character terminal that turns put-character, font-load and clear requests
// into glyph-row, scroll and clear commands for a 32-bit framebuffer.
// ----------------------------------------------------------------------------
// A put-character request that draws a cell yields GLYPH_ROWS glyph-row
// results, one per cycle while the master side takes them, since each row
// is one read of the font memory; the next request is taken in the cycle
// the last row is read. Scroll and clear requests yield one result; font
// loads, carriage returns and plain newlines yield none. The font memory is
// not cleared after reset: every glyph row must be loaded before it is drawn.
// Results wait in an output register, so a stalled master side holds the
// pending row while the next read is held back.
module text_console_glyph_renderer
  import tcgr_pkg::*;
#(
  parameter int GLYPH_ROWS  = 16,
  parameter int GLYPH_COUNT = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // slave side
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // char_code[7:0], fg_color[39:8], glyph_row[43:40], glyph_bits[51:44], zero pad
  input  logic [55:0] s_axis_tdata,
  // req_type[1:0]
  input  logic [1:0]  s_axis_tuser,
  // master side
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // pixel_x[11:0], pixel_y[23:12], pixel_mask[31:24], in_bounds[39:32],
  // pixel_color[71:40]
  output logic [71:0] m_axis_tdata,
  // cmd_kind[1:0]
  output logic [1:0]  m_axis_tuser,
  output logic        m_axis_tlast,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int RowW  = $clog2(GLYPH_ROWS);
  localparam int Recip = (65536 + GLYPH_ROWS - 1) / GLYPH_ROWS;

  function automatic logic [8:0] col_limit(input logic [11:0] w);
    logic [8:0] c;
    c = w[11:3];
    return (c >= 9'd2) ? (c - 9'd2) : 9'd0;
  endfunction

  // height / GLYPH_ROWS by reciprocal multiply, exact for 12-bit heights
  function automatic logic [8:0] row_limit(input logic [11:0] h);
    logic [27:0] p;
    logic [11:0] q;
    p = 28'(h) * 28'(Recip);
    q = p[27:16];
    return (q >= 12'd1) ? 9'(q - 12'd1) : 9'd0;
  endfunction

  // configuration registers
  logic [11:0] width_q, height_q;
  logic [8:0]  climit_q, rlimit_q;
  logic        cfg_we;

  // cursor
  logic [8:0] col_q, col_d;
  logic [7:0] row_q, row_d;

  // job register: drives the font reads
  logic              a_valid_q;
  cmd_kind_e         a_kind_q;
  logic [7:0]        a_glyph_q;
  logic [11:0]       a_px_q, a_py_q;
  logic [31:0]       a_color_q;
  logic [RowW-1:0]   a_cnt_q;
  logic              a_last, issue;

  // output register, aligned with the font read data
  logic        b_valid_q;
  cmd_kind_e   b_kind_q;
  logic [11:0] b_x_q, b_y_q;
  logic [7:0]  b_inb_q;
  logic [31:0] b_color_q;
  logic        b_last_q;
  logic        b_free;

  logic [7:0] font_mem [2**FontAw];
  logic [7:0] font_rd_q;

  // request decode
  req_type_e          req;
  logic [7:0]         code, gbits;
  logic [3:0]         grow;
  logic [31:0]        color;
  logic               in_acc;
  logic               new_job;
  cmd_kind_e          new_kind;
  logic [7:0]         new_glyph, glyph_mod;
  logic [11:0]        new_px, new_py;
  logic [8:0]         row_nx;
  logic [9:0]         col_inc;
  logic               draw;
  logic               font_we;

  // issue-side values
  logic [FontAw-1:0]  rd_addr;
  logic [11:0]        iss_x, iss_y, row_y;
  logic [7:0]         iss_inb;
  logic [31:0]        iss_color;

  assign req   = req_type_e'(s_axis_tuser);
  assign code  = s_axis_tdata[7:0];
  assign color = s_axis_tdata[39:8];
  assign grow  = s_axis_tdata[43:40];
  assign gbits = s_axis_tdata[51:44];

  assign a_last = (a_kind_q != CMD_GLYPH_ROW) || (a_cnt_q == RowW'(GLYPH_ROWS - 1));
  assign b_free = !b_valid_q || m_axis_tready;
  assign issue  = a_valid_q && b_free;

  assign s_axis_tready = !a_valid_q || (issue && a_last);
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // ---------------------------------------------------------------- config
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_comb begin
    unique case (paddr[2])
      REG_WIDTH:  prdata = {20'd0, width_q};
      REG_HEIGHT: prdata = {20'd0, height_q};
      default:    prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RST;
      height_q <= HEIGHT_RST;
      climit_q <= col_limit(WIDTH_RST);
      rlimit_q <= row_limit(HEIGHT_RST);
    end else if (cfg_we) begin
      if (paddr[2] == REG_WIDTH) begin
        width_q  <= pwdata[11:0];
        climit_q <= col_limit(pwdata[11:0]);
      end else begin
        height_q <= pwdata[11:0];
        rlimit_q <= row_limit(pwdata[11:0]);
      end
    end
  end

  // ---------------------------------------------------------------- decode
  always_comb begin
    col_d     = col_q;
    row_d     = row_q;
    new_job   = 1'b0;
    new_kind  = CMD_GLYPH_ROW;
    new_glyph = code;
    new_px    = {col_q, 3'b000};
    new_py    = 12'(row_q) * 12'(GLYPH_ROWS);
    row_nx    = {1'b0, row_q};
    col_inc   = {1'b0, col_q} + 10'd1;
    draw      = 1'b0;
    font_we   = 1'b0;
    if (in_acc) begin
      unique case (req)
        REQ_PUT_CHAR: begin
          draw = 1'b1;
          if (code == CH_NEWLINE) begin
            col_d  = 9'd0;
            row_nx = {1'b0, row_q} + 9'd1;
            draw   = 1'b0;
          end else if (code == CH_RETURN) begin
            col_d = 9'd0;
            draw  = 1'b0;
          end else if (code == CH_BACKSPACE) begin
            if (col_q != 9'd0) begin
              new_glyph = CH_SPACE;
              col_d     = col_q - 9'd1;
              new_px    = {col_q - 9'd1, 3'b000};
            end
          end else if (col_inc > {1'b0, climit_q}) begin
            col_d  = 9'd0;
            row_nx = {1'b0, row_q} + 9'd1;
          end else begin
            col_d = col_inc[8:0];
          end
          // carriage return never scrolls, even with the row past the limit
          if (code != CH_RETURN) begin
            if (row_nx > rlimit_q) begin
              row_d    = rlimit_q[7:0];
              new_job  = 1'b1;
              new_kind = CMD_SCROLL_UP;
            end else begin
              row_d   = row_nx[7:0];
              new_job = draw;
            end
          end
        end
        REQ_CLEAR: begin
          col_d    = 9'd0;
          row_d    = 8'd0;
          new_job  = 1'b1;
          new_kind = CMD_CLEAR_FB;
        end
        REQ_LOAD_FONT: begin
          font_we = ({1'b0, code} < 9'(GLYPH_COUNT)) && ({1'b0, grow} < 5'(GLYPH_ROWS));
        end
        default: ;
      endcase
    end
  end

  assign glyph_mod = ({1'b0, new_glyph} >= 9'(GLYPH_COUNT)) ?
                     (new_glyph - 8'(GLYPH_COUNT)) : new_glyph;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= 9'd0;
      row_q <= 8'd0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // ---------------------------------------------------------------- job
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      a_cnt_q   <= '0;
    end else begin
      if (issue) begin
        if (a_last) a_valid_q <= 1'b0;
        else        a_cnt_q   <= a_cnt_q + RowW'(1);
      end
      if (new_job) begin
        a_valid_q <= 1'b1;
        a_cnt_q   <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (new_job) begin
      a_kind_q  <= new_kind;
      a_glyph_q <= glyph_mod;
      a_px_q    <= new_px;
      a_py_q    <= new_py;
      a_color_q <= color;
    end
  end

  // ---------------------------------------------------------------- issue
  assign rd_addr = {a_glyph_q, FontStride'(a_cnt_q)};
  assign row_y   = a_py_q + 12'(a_cnt_q);

  always_comb begin
    iss_inb = '0;
    for (int i = 0; i < 8; i++) begin
      iss_inb[7-i] = (({1'b0, a_px_q} + 13'(i)) < {1'b0, width_q}) && (row_y < height_q);
    end
    iss_x     = a_px_q;
    iss_y     = row_y;
    iss_color = a_color_q;
    case (a_kind_q)
      CMD_SCROLL_UP: begin
        iss_inb   = '0;
        iss_x     = '0;
        iss_y     = 12'(GLYPH_ROWS);
        iss_color = '0;
      end
      CMD_CLEAR_FB: begin
        iss_inb   = '0;
        iss_x     = '0;
        iss_y     = '0;
        iss_color = '0;
      end
      default: ;
    endcase
  end

  // font memory: a load waits at the input until the last row of a pending
  // glyph is read; in that cycle the read still returns the old row
  always_ff @(posedge clk_i) begin
    if (font_we) font_mem[{code, grow}] <= gbits;
    if (issue)   font_rd_q <= font_mem[rd_addr];
  end

  // ---------------------------------------------------------------- output
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (issue) begin
      b_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      b_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      b_kind_q  <= a_kind_q;
      b_x_q     <= iss_x;
      b_y_q     <= iss_y;
      b_inb_q   <= iss_inb;
      b_color_q <= iss_color;
      b_last_q  <= a_last;
    end
  end

  assign m_axis_tvalid = b_valid_q;
  assign m_axis_tuser  = b_kind_q;
  assign m_axis_tlast  = b_last_q;
  // scroll and clear carry no in-bounds bits, so their mask drops to zero
  assign m_axis_tdata  = {b_color_q, b_inb_q, font_rd_q & b_inb_q, b_y_q, b_x_q};

endmodule
